@@ rtl/mnps_pkg.sv @@
// ----------------------------------------------------------------------------
// mnps_pkg
// shared types and constants for the mono note priority stack
// ----------------------------------------------------------------------------
package mnps_pkg;

    localparam int NOTE_W         = 7;
    localparam int LIST_DEPTH_DEF = 12;

    typedef logic [NOTE_W-1:0] t_note;

    typedef enum logic {
        OP_NOTE_OFF = 1'b0,
        OP_NOTE_ON  = 1'b1
    } t_opcode;

endpackage

@@ rtl/mono_note_priority_stack.sv @@
// ----------------------------------------------------------------------------
// mono_note_priority_stack
// last-note-priority held note list for a monophonic voice
// ----------------------------------------------------------------------------
// usage
//   an event (i_opcode, i_note_number) transfers at a rising edge with start
//   high and busy low. note on pushes the note to the front of the list,
//   dropping the oldest entry when the list is full; note off removes the
//   newest matching entry, or changes nothing when none matches.
//   each event gives exactly one result, shown for one cycle with o_valid:
//   gate, sounding note (0 while gate is low), retrigger and release edges,
//   and a list-changed flag. the receiver cannot stall; results are never
//   held back.
// timing
//   the list sits in one memory with a registered read. an event
//   walks the held entries once, one memory read per cycle, moving entries
//   through the write port as the read data returns. note on passes through
//   scan, drain, front and done (only front and done on an empty list);
//   note off passes through scan, drain and done (only done on an empty
//   list). o_valid is high in the first cycle with busy low. the length of
//   the walk over the memory port sets how long busy stays high.
// reset
//   i_rst_n low (synchronous) empties the list and clears the gate. the
//   memory is not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module mono_note_priority_stack #(
    parameter int LIST_DEPTH = mnps_pkg::LIST_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mnps_pkg::t_opcode i_opcode,
    input  mnps_pkg::t_note   i_note_number,
    output logic              o_valid,
    output logic              o_gate,
    output mnps_pkg::t_note   o_sounding_note,
    output logic              o_retrigger,
    output logic              o_release_res,
    output logic              o_list_changed
);
    import mnps_pkg::*;

    // address and count widths follow the list depth
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,   // issue one read per cycle
        S_DRAIN = 5'b00100,   // last read data returns
        S_FRONT = 5'b01000,   // write new note at the head
        S_DONE  = 5'b10000    // update count and gate, emit result
    } t_state;

    // control state
    t_state        r_state,  n_state;
    logic [CW-1:0] r_count,  n_count;
    logic          r_gate,   n_gate;
    logic          r_rd_vld, n_rd_vld;
    logic          r_valid,  n_valid;

    // per-event working registers
    t_opcode       r_op,      n_op;
    t_note         r_note,    n_note;
    t_note         r_front,   n_front;     // cached copy of entry 0
    logic [AW-1:0] r_idx,     n_idx;       // next read address
    logic [AW-1:0] r_rd_idx,  n_rd_idx;    // address of data now returning
    logic [CW-1:0] r_left,    n_left;      // reads still to issue
    logic [CW-1:0] r_cnt_new, n_cnt_new;   // count if the list changes
    logic          r_found,   n_found;

    // result registers
    logic          r_o_gate,    n_o_gate;
    t_note         r_o_note,    n_o_note;
    logic          r_o_retrig,  n_o_retrig;
    logic          r_o_release, n_o_release;
    logic          r_o_changed, n_o_changed;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_note         ram_wdata;
    logic          ram_re;
    t_note         ram_rdata;

    logic [CW-1:0] clip_count;
    logic          changed;

    mnps_ram #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // a full list gives up its oldest slot before the push
    assign clip_count = (r_count >= CW'(LIST_DEPTH)) ? CW'(LIST_DEPTH - 1) : r_count;
    assign changed    = (r_op == OP_NOTE_ON) || r_found;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_gate      = r_gate;
        n_rd_vld    = 1'b0;
        n_valid     = 1'b0;
        n_op        = r_op;
        n_note      = r_note;
        n_front     = r_front;
        n_idx       = r_idx;
        n_rd_idx    = r_rd_idx;
        n_left      = r_left;
        n_cnt_new   = r_cnt_new;
        n_found     = r_found;
        n_o_gate    = r_o_gate;
        n_o_note    = r_o_note;
        n_o_retrig  = r_o_retrig;
        n_o_release = r_o_release;
        n_o_changed = r_o_changed;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;

        // returning read data: push moves each entry one place older,
        // removal moves every entry past the match one place newer
        if (r_rd_vld) begin
            if (r_op == OP_NOTE_ON) begin
                ram_we    = 1'b1;
                ram_waddr = r_rd_idx + AW'(1);
            end else if (r_found) begin
                ram_we    = 1'b1;
                ram_waddr = r_rd_idx - AW'(1);
                if (r_rd_idx == AW'(1)) begin
                    n_front = ram_rdata;
                end
            end else if (ram_rdata == r_note) begin
                n_found = 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_opcode;
                    n_note  = i_note_number;
                    n_found = 1'b0;
                    if (i_opcode == OP_NOTE_ON) begin
                        // walk from the oldest kept entry toward the head
                        n_left    = clip_count;
                        n_cnt_new = clip_count + CW'(1);
                        n_idx     = AW'(clip_count - CW'(1));
                        n_state   = (clip_count == '0) ? S_FRONT : S_SCAN;
                    end else begin
                        // search from the newest entry
                        n_left    = r_count;
                        n_cnt_new = r_count - CW'(1);
                        n_idx     = '0;
                        n_state   = (r_count == '0) ? S_DONE : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                ram_re   = 1'b1;
                n_rd_vld = 1'b1;
                n_rd_idx = r_idx;
                n_idx    = (r_op == OP_NOTE_ON) ? r_idx - AW'(1) : r_idx + AW'(1);
                n_left   = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = (r_op == OP_NOTE_ON) ? S_FRONT : S_DONE;
            end
            S_FRONT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_note;
                n_front   = r_note;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (changed) begin
                    n_count = r_cnt_new;
                    n_gate  = (r_cnt_new != '0);
                end
                n_valid     = 1'b1;
                n_o_gate    = n_gate;
                n_o_note    = n_gate ? r_front : '0;
                n_o_retrig  = changed && n_gate && !r_gate;
                n_o_release = changed && !n_gate && r_gate;
                n_o_changed = changed;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_gate   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_gate   <= n_gate;
            r_rd_vld <= n_rd_vld;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_note      <= n_note;
        r_front     <= n_front;
        r_idx       <= n_idx;
        r_rd_idx    <= n_rd_idx;
        r_left      <= n_left;
        r_cnt_new   <= n_cnt_new;
        r_found     <= n_found;
        r_o_gate    <= n_o_gate;
        r_o_note    <= n_o_note;
        r_o_retrig  <= n_o_retrig;
        r_o_release <= n_o_release;
        r_o_changed <= n_o_changed;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_gate          = r_o_gate;
    assign o_sounding_note = r_o_note;
    assign o_retrigger     = r_o_retrig;
    assign o_release_res   = r_o_release;
    assign o_list_changed  = r_o_changed;

    // gate follows the held count
    ap_gate_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gate == (r_count != '0))
        else $error("gate does not match held count");

    // count never exceeds the list depth
    ap_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("held count above list depth");

    // an accepted event keeps the block busy next cycle
    ap_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted event did not raise busy");

    // edges only on a changed list, and consistent with the new gate
    ap_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_retrigger || o_release_res) |->
            o_list_changed && (o_retrigger == o_gate) && !(o_retrigger && o_release_res))
        else $error("gate edge flags inconsistent");

    // read data only returns while the walk is in progress
    ap_read_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("read data returned outside the walk");

endmodule

@@ rtl/mnps_ram.sv @@
// ----------------------------------------------------------------------------
// mnps_ram
// held note list storage, one write and one registered read port
// ----------------------------------------------------------------------------
module mnps_ram #(
    parameter int DEPTH = mnps_pkg::LIST_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  mnps_pkg::t_note i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr,
    output mnps_pkg::t_note o_rdata
);
    import mnps_pkg::*;

    t_note r_mem [DEPTH];
    t_note r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
